// File: hw/rtl/rbm_pkg.sv
`default_nettype none

package rbm_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int BRIGHT_W    = CH_W + 2;
	localparam int FW_W        = 11;
	localparam int FH_W        = 16;
	localparam int ROW_W       = 16;
	localparam int COL_FIELD_W = 10;

	localparam int WIN_N       = 9;
	localparam int MEDIAN_RANK = 4;

	localparam int FIFO_DEPTH  = 4;

	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// red in the top byte, blue in the bottom byte
	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [ROW_W-1:0]       out_row;
		logic [COL_FIELD_W-1:0] out_col;
		logic [CH_W-1:0]        red_out;
		logic [CH_W-1:0]        green_out;
		logic [CH_W-1:0]        blue_out;
		logic                   last_of_run;
	} pix_out_t;

	// what an item carries down the pipeline besides its window
	typedef struct packed {
		logic                   med;
		logic                   brd;
		logic [ROW_W-1:0]       med_row;
		logic [COL_FIELD_W-1:0] med_col;
		logic [ROW_W-1:0]       brd_row;
		logic [COL_FIELD_W-1:0] brd_col;
		pixel_t                 brd_px;
	} tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/rbm_rank.sv
`default_nettype none

module rbm_rank
	import rbm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid,
	input  wire pixel_t win [WIN_N],
	input  wire tag_t   tag,
	output logic        valid_s4,
	output pixel_t      median,
	output tag_t        tag_s4
);

	localparam int RANK_W = $clog2(WIN_N);

	logic                v_s2, v_s3;
	pixel_t              win_s2 [WIN_N];
	pixel_t              win_s3 [WIN_N];
	pixel_t              win_s4 [WIN_N];
	tag_t                tag_s2, tag_s3;
	logic [BRIGHT_W-1:0] bright_s3 [WIN_N];
	logic [WIN_N-1:0]    before_s4 [WIN_N];
	logic [WIN_N-1:0]    before_c [WIN_N];
	logic [RANK_W-1:0]   rank [WIN_N];
	logic [WIN_N-1:0]    sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			v_s2     <= valid;
			v_s3     <= v_s2;
			valid_s4 <= v_s3;
		end
	end

	// before_c[k][m]: window pixel m sorts ahead of pixel k (stable order)
	always_comb begin
		for (int k = 0; k < WIN_N; k++) begin
			for (int m = 0; m < WIN_N; m++) begin
				before_c[k][m] = (bright_s3[m] < bright_s3[k]) ||
					((bright_s3[m] == bright_s3[k]) && (m < k));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s2 <= win;
			tag_s2 <= tag;
			for (int k = 0; k < WIN_N; k++) begin
				bright_s3[k] <= BRIGHT_W'(win_s2[k][23:16]) + BRIGHT_W'(win_s2[k][15:8]) +
					BRIGHT_W'(win_s2[k][7:0]);
			end
			win_s3    <= win_s2;
			tag_s3    <= tag_s2;
			before_s4 <= before_c;
			win_s4    <= win_s3;
			tag_s4    <= tag_s3;
		end
	end

	always_comb begin
		median = '0;
		for (int k = 0; k < WIN_N; k++) begin
			rank[k] = '0;
			for (int m = 0; m < WIN_N; m++) begin
				rank[k] = rank[k] + RANK_W'(before_s4[k][m]);
			end
			sel[k] = (rank[k] == RANK_W'(MEDIAN_RANK));
			median = median | (win_s4[k] & {PIX_W{sel[k]}});
		end
	end

	// the stable ranks form a permutation, so exactly one pixel holds the middle rank;
	// only a full window is checked, border items may carry unwritten store data
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && tag_s4.med) |-> $onehot(sel))
		else $error("median select is not one-hot");

endmodule

`default_nettype wire

// File: hw/rtl/rgb_brightness_median_3x3.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// pix     | in        | pix_valid, pix_stall | pix_in_t: red_in, green_in, blue_in
// res     | out       | res_valid, res_stall | pix_out_t: row, col, rgb, last_of_run
// apb     | in        | psel, penable, pready| frame_width @0x0, frame_height @0x4
//
// One pixel per clock is accepted while pix_stall is low; each result passes through
// stage 1, the ranking pipeline and the output queue before it is offered.
// The line stores are read when a pixel is accepted and written when that item leaves
// stage 1, bypassed when the next pixel reads the same column (frame width of one).
// Rows that give two results per pixel fill the four-entry output queue and
// stall the input; the whole pipeline holds while three or more results wait.
// Reset clears counters and valids; the line stores need no clearing pass.

module rgb_brightness_median_3x3
	import rbm_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire pix_in_t           pix,

	output logic                   res_valid,
	input  wire logic              res_stall,
	output pix_out_t               res,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW    = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// configuration
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic             cfg_wr;
	logic [EW-1:0]    fw_ext;
	logic [EW-1:0]    eff_w;
	logic [FH_W-1:0]  eff_h;

	// frame position of the next pixel
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             adv;
	logic             take;
	pixel_t           px;
	tag_t             tag_c;

	// stage 1: line store read data, window assembly
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	tag_t             tag_s1;
	pixel_t           up_s1, mid_s1;
	logic             fwd_s1;
	pixel_t           fwd_up_s1, fwd_mid_s1;
	pixel_t           up_eff, mid_eff;
	pixel_t           upper_mem [MAX_WIDTH];
	pixel_t           middle_mem [MAX_WIDTH];
	pixel_t           hist_q [6];
	pixel_t           win [WIN_N];

	// stage 4 out of the ranking pipeline
	logic             v_s4;
	pixel_t           median;
	tag_t             tag_s4;

	// output queue
	pix_out_t         fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] tail;
	logic             push;
	logic             pop;
	logic [CNT_W-1:0] push_n;
	pix_out_t         med_res, brd_res;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_FRAME_WIDTH:  prdata = DATA_W'(fw_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(fh_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[FH_W-1:0];
				default:          ;
			endcase
		end
	end

	assign fw_ext = EW'(fw_q);

	always_comb begin
		if (fw_q == '0) begin
			eff_w = EW'(1);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
	end

	assign eff_h = (fh_q == '0) ? FH_W'(1) : fh_q;

	// ---------------- input side and frame counters ----------------
	assign adv       = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign pix_stall = !adv;
	assign take      = pix_valid && adv;
	assign px        = {pix.red_in, pix.green_in, pix.blue_in};

	always_comb begin
		tag_c.med     = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		tag_c.brd     = (row_q == '0) || (row_q == eff_h - FH_W'(1)) || (col_q == '0) ||
			(EW'(col_q) == eff_w - EW'(1));
		tag_c.med_row = row_q - ROW_W'(1);
		tag_c.med_col = COL_FIELD_W'(col_q - COL_W'(1));
		tag_c.brd_row = row_q;
		tag_c.brd_col = COL_FIELD_W'(col_q);
		tag_c.brd_px  = px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (EW'(col_q) + EW'(1) >= eff_w) begin
				col_q <= '0;
				if ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(eff_h)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------- stage 1: line stores ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1     <= col_q;
			tag_s1     <= tag_c;
			// the write of the item leaving stage 1 lands after this read: bypass it
			fwd_s1     <= v_s1 && (col_s1 == col_q);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= tag_s1.brd_px;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			up_s1  <= upper_mem[col_q];
			mid_s1 <= middle_mem[col_q];
		end
		if (adv && v_s1) begin
			upper_mem[col_s1]  <= mid_eff;
			middle_mem[col_s1] <= tag_s1.brd_px;
		end
	end

	assign up_eff  = fwd_s1 ? fwd_up_s1 : up_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_s1;

	always_comb begin
		win[0] = hist_q[0];
		win[1] = hist_q[3];
		win[2] = up_eff;
		win[3] = hist_q[1];
		win[4] = hist_q[4];
		win[5] = mid_eff;
		win[6] = hist_q[2];
		win[7] = hist_q[5];
		win[8] = tag_s1.brd_px;
	end

	// shift the two previous window columns
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			hist_q[0] <= hist_q[3];
			hist_q[1] <= hist_q[4];
			hist_q[2] <= hist_q[5];
			hist_q[3] <= up_eff;
			hist_q[4] <= mid_eff;
			hist_q[5] <= tag_s1.brd_px;
		end
	end

	// ---------------- stages 2 to 4: ranking ----------------
	rbm_rank u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (v_s1),
		.win      (win),
		.tag      (tag_s1),
		.valid_s4 (v_s4),
		.median   (median),
		.tag_s4   (tag_s4)
	);

	// ---------------- output queue ----------------
	always_comb begin
		med_res.out_row     = tag_s4.med_row;
		med_res.out_col     = tag_s4.med_col;
		med_res.red_out     = median[23:16];
		med_res.green_out   = median[15:8];
		med_res.blue_out    = median[7:0];
		med_res.last_of_run = !tag_s4.brd;

		brd_res.out_row     = tag_s4.brd_row;
		brd_res.out_col     = tag_s4.brd_col;
		brd_res.red_out     = tag_s4.brd_px[23:16];
		brd_res.green_out   = tag_s4.brd_px[15:8];
		brd_res.blue_out    = tag_s4.brd_px[7:0];
		brd_res.last_of_run = 1'b1;
	end

	assign push      = adv && v_s4;
	assign push_n    = push ? (CNT_W'(tag_s4.med) + CNT_W'(tag_s4.brd)) : '0;
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign tail      = head_q + PTR_W'(cnt_q);
	assign res       = fifo_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_q + PTR_W'(pop);
			cnt_q  <= cnt_q + push_n - CNT_W'(pop);
		end
	end

	// median of the window first, then the border pixel that just arrived
	always_ff @(posedge clk) begin
		if (push) begin
			if (tag_s4.med) begin
				fifo_q[tail] <= med_res;
				if (tag_s4.brd) begin
					fifo_q[tail + PTR_W'(1)] <= brd_res;
				end
			end else if (tag_s4.brd) begin
				fifo_q[tail] <= brd_res;
			end
		end
	end

	// ---------------- assertions ----------------
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(push_n) <= (CNT_W + 1)'(FIFO_DEPTH)))
		else $error("output queue overflow on transfer into queue");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < eff_w)
		else $error("column counter outside frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < eff_h)
		else $error("row counter outside frame height");

endmodule

`default_nettype wire
